// ===== design/ssnfw_pkg.sv =====
// Shared types, constants and segment table for the seven-segment frame writer.
package ssnfw_pkg;

    localparam int VALUE_W = 27;
    localparam int DIGITS  = 8;
    localparam int BCD_W   = 4 * DIGITS;
    localparam int SHIFT_W = 5;

    localparam logic [VALUE_W-1:0] VALUE_MOD  = 27'd100000000;
    localparam logic [SHIFT_W-1:0] SHIFT_LAST = 5'(VALUE_W - 1);

    localparam logic [7:0] CMD_AUTO  = 8'h40;
    localparam logic [7:0] CMD_FIXED = 8'h44;
    localparam logic [7:0] ADDR_BASE = 8'hC0;
    localparam logic [7:0] POINT_BIT = 8'h80;

    typedef struct packed {
        logic [7:0]            addr;
        logic [3:0]            count;
        logic                  point;
        logic [DIGITS-1:0][3:0] bcd;
    } job_t;

    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] c;
        unique case (d)
            4'd0: c = 8'h3f;
            4'd1: c = 8'h06;
            4'd2: c = 8'h5b;
            4'd3: c = 8'h4f;
            4'd4: c = 8'h66;
            4'd5: c = 8'h6d;
            4'd6: c = 8'h7d;
            4'd7: c = 8'h07;
            4'd8: c = 8'h7f;
            4'd9: c = 8'h6f;
            default: c = 8'h3f;
        endcase
        return c;
    endfunction

endpackage

// ===== design/ssnfw_front.sv =====
// Front end: takes requests, reduces the value and converts it to BCD by shift-and-add-3.
module ssnfw_front #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [4:0]                    s_start_position,
    input  logic [3:0]                    s_digit_count,
    input  logic [ssnfw_pkg::VALUE_W-1:0] s_value,
    input  logic                          s_decimal_point,
    output logic                          job_valid,
    input  logic                          job_ready,
    output ssnfw_pkg::job_t               job
);
    import ssnfw_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CONV = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;
    localparam logic [3:0] CNT_MAX = 4'(MAX_DIGITS);

    logic [1:0]         state_reg, state_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [7:0]         addr_reg, addr_next;
    logic [3:0]         count_reg, count_next;
    logic               point_reg, point_next;
    logic [BCD_W-1:0]   bcd_adj;

    always_comb begin
        for (int n = 0; n < DIGITS; n++) begin
            bcd_adj[4*n +: 4] = (bcd_reg[4*n +: 4] >= 4'd5) ?
                                bcd_reg[4*n +: 4] + 4'd3 : bcd_reg[4*n +: 4];
        end
    end

    always_comb begin
        state_next = state_reg;
        shift_next = shift_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        addr_next  = addr_reg;
        count_next = count_reg;
        point_next = point_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    state_next = F_CONV;
                    shift_next = '0;
                    bcd_next   = '0;
                    bin_next   = (s_value >= VALUE_MOD) ? s_value - VALUE_MOD : s_value;
                    addr_next  = ADDR_BASE + {3'b000, s_start_position} - 8'd1;
                    count_next = (s_digit_count > CNT_MAX) ? CNT_MAX : s_digit_count;
                    point_next = s_decimal_point;
                end
            end
            F_CONV: begin
                {bcd_next, bin_next} = {bcd_adj, bin_reg} << 1;
                shift_next = shift_reg + 5'd1;
                if (shift_reg == SHIFT_LAST) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (job_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        shift_reg <= shift_next;
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        addr_reg  <= addr_next;
        count_reg <= count_next;
        point_reg <= point_next;
    end

    assign s_ready   = (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_PUSH);
    assign job.addr  = addr_reg;
    assign job.count = count_reg;
    assign job.point = point_reg;
    assign job.bcd   = bcd_reg;

endmodule

// ===== design/ssnfw_queue.sv =====
// Two-entry job queue between the converter and the byte sequencer.
module ssnfw_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ssnfw_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output ssnfw_pkg::job_t head
);
    import ssnfw_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 2'd2) else $error("queue fill out of range");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full || pop) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty) else $error("queue pop while empty");
`endif

endmodule

// ===== design/ssnfw_back.sv =====
// Back end: walks one job and emits its framed command, address and segment bytes.
module ssnfw_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fixed_mode,
    input  logic            job_avail,
    input  ssnfw_pkg::job_t job,
    output logic            job_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_start_before,
    output logic            m_stop_after,
    output logic            m_last
);
    import ssnfw_pkg::*;

    localparam logic [1:0] B_CMD  = 2'd0;
    localparam logic [1:0] B_ADDR = 2'd1;
    localparam logic [1:0] B_DATA = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       st_reg, st_next;
    logic       sp_reg, sp_next;
    logic       last_reg, last_next;

    logic       load;
    logic [3:0] didx;
    logic [3:0] digit;
    logic       final_digit;
    logic       empty_job;

    assign load        = job_avail && (!valid_reg || m_ready);
    assign didx        = job.count - 4'd1 - idx_reg;
    assign digit       = (didx < 4'(DIGITS)) ? job.bcd[didx[2:0]] : 4'd0;
    assign final_digit = (idx_reg == job.count - 4'd1);
    assign empty_job   = (job.count == 4'd0);

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_ready;
        byte_next  = byte_reg;
        st_next    = st_reg;
        sp_next    = sp_reg;
        last_next  = last_reg;
        job_pop    = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            unique case (phase_reg)
                B_CMD: begin
                    byte_next  = fixed_mode ? CMD_FIXED : CMD_AUTO;
                    st_next    = 1'b1;
                    sp_next    = 1'b1;
                    last_next  = fixed_mode && empty_job;
                    phase_next = B_ADDR;
                end
                B_ADDR: begin
                    byte_next  = fixed_mode ? job.addr + {4'b0000, idx_reg} : job.addr;
                    st_next    = 1'b1;
                    sp_next    = !fixed_mode && empty_job;
                    last_next  = !fixed_mode && empty_job;
                    phase_next = B_DATA;
                end
                B_DATA: begin
                    byte_next  = seg_code(digit) |
                                 ((job.point && didx == 4'd0) ? POINT_BIT : 8'h00);
                    st_next    = 1'b0;
                    sp_next    = fixed_mode || final_digit;
                    last_next  = final_digit;
                    idx_next   = idx_reg + 4'd1;
                    phase_next = fixed_mode ? B_ADDR : B_DATA;
                end
                default: begin
                    phase_next = B_CMD;
                    valid_next = 1'b0;
                end
            endcase
            if (last_next) begin
                job_pop    = 1'b1;
                phase_next = B_CMD;
                idx_next   = 4'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= B_CMD;
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
        st_reg   <= st_next;
        sp_reg   <= sp_next;
        last_reg <= last_next;
    end

    assign m_valid        = valid_reg;
    assign m_out_byte     = byte_reg;
    assign m_start_before = st_reg;
    assign m_stop_after   = sp_reg;
    assign m_last         = last_reg;

endmodule

// ===== design/seven_segment_number_frame_writer.sv =====
// Top level of the seven-segment number frame writer: register, converter, queue, sequencer.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    start_position, digit_count, value, decimal_point
//   m_       out        m_valid/m_ready    out_byte, start_before, stop_after, last
//   cfg_     in         cfg_wr_en          cfg_wr_data (fixed_address_mode)
//
// The converter takes one request at a time: load, a 27-step BCD shift, then hand-off.
// Sequencer: one byte per cycle if m_ready; count+2 bytes (auto) or 2*count+1 (fixed).
// The two-entry queue lets conversion of the next request overlap byte output.
// Reset is synchronous, active low; the mode register resets to auto-increment.
// Output stalls hold the byte register; the converter stalls only when the queue is full.
module seven_segment_number_frame_writer #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [4:0]                    s_start_position,
    input  logic [3:0]                    s_digit_count,
    input  logic [ssnfw_pkg::VALUE_W-1:0] s_value,
    input  logic                          s_decimal_point,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_byte,
    output logic                          m_start_before,
    output logic                          m_stop_after,
    output logic                          m_last
);
    import ssnfw_pkg::*;

    logic fixed_mode_reg, fixed_mode_next;
    logic job_valid, q_full, q_avail, q_pop;
    job_t job_in, job_head;

    assign fixed_mode_next = cfg_wr_en ? cfg_wr_data : fixed_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fixed_mode_reg <= 1'b0;
        end else begin
            fixed_mode_reg <= fixed_mode_next;
        end
    end

    ssnfw_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_start_position (s_start_position),
        .s_digit_count    (s_digit_count),
        .s_value          (s_value),
        .s_decimal_point  (s_decimal_point),
        .job_valid        (job_valid),
        .job_ready        (!q_full),
        .job              (job_in)
    );

    ssnfw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_valid && !q_full),
        .push_job  (job_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_avail),
        .head      (job_head)
    );

    ssnfw_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fixed_mode     (fixed_mode_reg),
        .job_avail      (q_avail),
        .job            (job_head),
        .job_pop        (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_start_before (m_start_before),
        .m_stop_after   (m_stop_after),
        .m_last         (m_last)
    );

endmodule

// ===== tb/frame_byte_checker.sv =====
// Checker for the seven-segment frame writer: predicts the framed byte stream and compares it.
module frame_byte_checker #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [4:0]                    s_start_position,
    input  logic [3:0]                    s_digit_count,
    input  logic [ssnfw_pkg::VALUE_W-1:0] s_value,
    input  logic                          s_decimal_point,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [7:0]                    m_out_byte,
    input  logic                          m_start_before,
    input  logic                          m_stop_after,
    input  logic                          m_last,
    output int                            mismatch_count,
    output int                            bytes_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ssnfw_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic       start_before;
        logic       stop_after;
        logic       last;
    } display_byte_t;

    localparam logic [7:0] SEGMENTS [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    display_byte_t expected_bytes[$];
    logic          fixed_mode = 1'b0;
    int            mismatches = 0;

    function automatic logic [7:0] digit_segments(input int unsigned number,
                                                  input int unsigned idx,
                                                  input logic point);
        int unsigned rest;
        logic [7:0]  code;
        rest = number;
        repeat (idx) rest = rest / 10;
        if (idx >= DIGITS) rest = 0;
        code = SEGMENTS[rest % 10];
        if (point) code = code | POINT_BIT;
        return code;
    endfunction

    function automatic void add_byte(input logic [7:0] code, input logic st,
                                     input logic sp, input logic fin);
        expected_bytes.push_back('{code, st, sp, fin});
    endfunction

    function automatic void predict_frame(input logic [4:0] pos, input logic [3:0] count_in,
                                          input logic [VALUE_W-1:0] raw_value,
                                          input logic point);
        logic [7:0]  addr;
        int unsigned count;
        int unsigned number;
        int unsigned idx;
        int unsigned i;
        addr = ADDR_BASE + 8'(pos) - 8'd1;
        count = (count_in > MAX_DIGITS) ? MAX_DIGITS : count_in;
        number = 32'(raw_value) % 32'd100000000;
        if (fixed_mode) begin
            add_byte(CMD_FIXED, 1'b1, 1'b1, count == 0);
            for (i = 0; i < count; i++) begin
                idx = count - 1 - i;
                add_byte(addr + 8'(i), 1'b1, 1'b0, 1'b0);
                add_byte(digit_segments(number, idx, point && idx == 0), 1'b0, 1'b1,
                         i == count - 1);
            end
        end else begin
            add_byte(CMD_AUTO, 1'b1, 1'b1, 1'b0);
            add_byte(addr, 1'b1, count == 0, count == 0);
            for (i = 0; i < count; i++) begin
                idx = count - 1 - i;
                add_byte(digit_segments(number, idx, point && idx == 0), 1'b0,
                         i == count - 1, i == count - 1);
            end
        end
    endfunction

    always @(posedge aclk) begin
        display_byte_t got;
        display_byte_t want;
        if (!aresetn) begin
            expected_bytes.delete();
            fixed_mode = 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_frame(s_start_position, s_digit_count, s_value, s_decimal_point);
            if (cfg_wr_en) fixed_mode = cfg_wr_data;
            if (m_valid && m_ready) begin
                got = '{m_out_byte, m_start_before, m_stop_after, m_last};
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected byte %02h start %0b stop %0b last %0b",
                                 got.code, got.start_before, got.stop_after, got.last);
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.code !== want.code || got.start_before !== want.start_before ||
                        got.stop_after !== want.stop_after || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                                     want.code, want.start_before, want.stop_after, want.last,
                                     got.code, got.start_before, got.stop_after, got.last);
                    end
                end
            end
        end
        mismatch_count <= mismatches;
        bytes_pending <= expected_bytes.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the frame writer testbench: clock, reset, mode writes, request stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ssnfw_pkg::*;

    localparam logic       MODE_AUTO     = 1'b0;
    localparam logic       MODE_FIXED    = 1'b1;
    localparam logic [0:5] PHASE_MODES   = {MODE_AUTO, MODE_FIXED, MODE_AUTO,
                                            MODE_FIXED, MODE_FIXED, MODE_AUTO};
    localparam int         PHASE_ITEMS   = 21;
    localparam int         MAX_GAP       = 10;
    localparam int         SETTLE_CYCLES = 64;
    localparam int         CYCLE_LIMIT   = 200000;

    logic               aclk             = 1'b0;
    logic               aresetn          = 1'b0;
    logic               cfg_wr_en        = 1'b0;
    logic               cfg_wr_data      = 1'b0;
    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic [4:0]         s_start_position = '0;
    logic [3:0]         s_digit_count    = '0;
    logic [VALUE_W-1:0] s_value          = '0;
    logic               s_decimal_point  = 1'b0;
    logic               m_valid;
    logic               m_ready          = 1'b0;
    logic [7:0]         m_out_byte;
    logic               m_start_before;
    logic               m_stop_after;
    logic               m_last;

    int mismatch_count;
    int bytes_pending;
    int out_wait    = 0;
    int cycle_count = 0;
    bit steady      = 1'b0;

    seven_segment_number_frame_writer uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_start_position (s_start_position),
        .s_digit_count    (s_digit_count),
        .s_value          (s_value),
        .s_decimal_point  (s_decimal_point),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_start_before   (m_start_before),
        .m_stop_after     (m_stop_after),
        .m_last           (m_last)
    );

    frame_byte_checker frame_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_start_position (s_start_position),
        .s_digit_count    (s_digit_count),
        .s_value          (s_value),
        .s_decimal_point  (s_decimal_point),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_start_before   (m_start_before),
        .m_stop_after     (m_stop_after),
        .m_last           (m_last),
        .mismatch_count   (mismatch_count),
        .bytes_pending    (bytes_pending)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return steady ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // receiver stall: after each byte, ready drops for a drawn number of cycles, possibly none
    always @(posedge aclk) begin
        if (!aresetn) begin
            out_wait = 0;
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                out_wait = draw_gap();
            else if (out_wait > 0)
                out_wait--;
            m_ready <= (out_wait == 0);
        end
    end

    task automatic send_number(input logic [4:0] pos, input logic [3:0] count,
                               input logic [VALUE_W-1:0] number, input logic point);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_start_position <= pos;
        s_digit_count    <= count;
        s_value          <= number;
        s_decimal_point  <= point;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random_number(input bit well_formed);
        logic [4:0]         pos;
        logic [3:0]         count;
        logic [VALUE_W-1:0] number;
        int unsigned        span;
        if (well_formed) begin
            pos   = 5'($urandom_range(1, 16));
            count = 4'($urandom_range(1, 8));
            span  = 1;
            repeat ($urandom_range(1, 8)) span *= 10;
            number = VALUE_W'($urandom_range(0, span - 1));
        end else begin
            pos    = 5'($urandom_range(0, 31));
            count  = 4'($urandom_range(0, 15));
            number = VALUE_W'($urandom());
        end
        send_number(pos, count, number, 1'($urandom_range(0, 1)));
    endtask

    task automatic run_directed();
        send_number(5'd1, 4'd8, 27'd12345678, 1'b0);
        send_number(5'd1, 4'd8, 27'd90123456, 1'b1);
        send_number(5'd16, 4'd8, 27'd99999999, 1'b1);
        send_number(5'd1, 4'd1, 27'd0, 1'b0);
        send_number(5'd5, 4'd4, 27'd7, 1'b1);
        send_number(5'd1, 4'd0, 27'd42, 1'b1);
        send_number(5'd3, 4'd9, 27'd87654321, 1'b0);
        send_number(5'd2, 4'd15, 27'h7FFFFFF, 1'b1);
        send_number(5'd0, 4'd3, 27'd100000000, 1'b0);
        send_number(5'd31, 4'd8, 27'h7FFFFFF, 1'b0);
        send_number(5'd17, 4'd2, 27'd55, 1'b1);
        send_number(5'd8, 4'd6, 27'd654321, 1'b0);
    endtask

    // let the last frame drain completely before touching the mode register
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (bytes_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic mode);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int phase;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        wait_idle();
        write_mode(MODE_FIXED);
        run_directed();
        wait_idle();
        for (phase = 0; phase < 6; phase++) begin
            write_mode(PHASE_MODES[phase]);
            steady = (phase == 2 || phase == 4);
            repeat (PHASE_ITEMS) send_random_number($urandom_range(0, 4) != 0);
            wait_idle();
        end
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("testbench: errors");
        $finish;
    end

endmodule
